FILE: hw/rtl/oht_pkg.sv
package oht_pkg;

  // Default table size
  localparam int SLOTS_DEF = 32;

  // Free-slot search looks at one group of used marks per cycle
  localparam int GROUP_BITS = 3;
  localparam int GROUP_SIZE = 1 << GROUP_BITS;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKEND_PRESENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIM         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLIT_MAX_PIXELS = 2'd2;

  // Register reset values
  localparam logic [15:0] MAX_DIM_RST         = 16'd4096;
  localparam logic [31:0] BLIT_MAX_PIXELS_RST = 32'd1048576;

  // Request modes
  localparam logic [2:0] MODE_CREATE  = 3'd0;
  localparam logic [2:0] MODE_FILL    = 3'd1;
  localparam logic [2:0] MODE_BLIT    = 3'd2;
  localparam logic [2:0] MODE_POLL    = 3'd3;
  localparam logic [2:0] MODE_DESTROY = 3'd4;
  localparam logic [2:0] MODE_RELEASE = 3'd5;

  // Kinds of result that the controller asks the datapath to issue
  localparam logic [2:0] RK_REFUSE      = 3'd0;
  localparam logic [2:0] RK_REFUSE_CALL = 3'd1;
  localparam logic [2:0] RK_CREATED     = 3'd2;
  localparam logic [2:0] RK_ACCESS      = 3'd3;
  localparam logic [2:0] RK_DONE        = 3'd4;
  localparam logic [2:0] RK_DESTROY     = 3'd5;
  localparam logic [2:0] RK_FREED       = 3'd6;

  localparam int HANDLE_OUT_W = 6;

  typedef struct packed {
    logic [2:0]         mode;
    logic [31:0]        caller_id;
    logic [63:0]        handle;
    logic [31:0]        width;
    logic [31:0]        height;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic               buffer_given;
    logic signed [31:0] backend_answer;
  } req_t;

  typedef struct packed {
    logic                    status;
    logic [HANDLE_OUT_W-1:0] handle_out;
    logic signed [31:0]      backend_ref;
    logic                    call_backend;
    logic                    last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    logic [2:0] kind;
    logic       rd_handle;
    logic       rd_walk;
    logic       search_clr;
    logic       search_inc;
    logic       walk_clr;
    logic       walk_inc;
  } oht_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       pid_zero;
    logic       create_ok;
    logic       handle_ok;
    logic       owned;
    logic       dims_ok;
    logic       prod_ok;
    logic       buf_ok;
    logic       blit_zero;
    logic       bp;
    logic       ans_ok;
    logic       grp_free;
    logic       grp_last;
    logic       walk_hit;
    logic       walk_last;
  } oht_stat_t;

endpackage

FILE: hw/rtl/oht_dpath.sv
module oht_dpath import oht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  req_t                  request,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  oht_cmd_t              cmd,
  output oht_stat_t             stat,
  output res_t                  result,
  output logic                  result_valid
);

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NGRP   = (SLOTS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GRP_W  = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD    = NGRP * GROUP_SIZE;
  localparam int FULL_W = GRP_W + GROUP_BITS;

  req_t               req;
  logic               backend_present;
  logic [15:0]        max_dim;
  logic [31:0]        blit_max_pixels;
  logic [SLOTS-1:0]   used;
  logic [31:0]        owner_mem [SLOTS];
  logic signed [31:0] backend_mem [SLOTS];
  logic [31:0]        rd_owner;
  logic signed [31:0] rd_backend;
  logic [63:0]        prod;
  logic [GRP_W-1:0]   grp;
  logic [IDX_W-1:0]   walk_cnt;
  res_t               res_next;

  logic [PAD-1:0]        used_pad;
  logic [GROUP_SIZE-1:0] grp_bits;
  logic [GROUP_BITS-1:0] free_low;
  logic [FULL_W-1:0]     free_full;
  logic [FULL_W:0]       new_handle;
  logic [IDX_W-1:0]      free_idx;
  logic [IDX_W-1:0]      hidx;
  logic [IDX_W-1:0]      rd_addr;
  logic [31:0]           md32;
  logic                  cfg_clear;

  // Request register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      backend_present <= 1'b0;
      max_dim         <= MAX_DIM_RST;
      blit_max_pixels <= BLIT_MAX_PIXELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BACKEND_PRESENT: backend_present <= cfg_data[0];
        CFG_MAX_DIM:         max_dim <= cfg_data[15:0];
        CFG_BLIT_MAX_PIXELS: blit_max_pixels <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign cfg_clear = cfg_we && (cfg_index == CFG_BACKEND_PRESENT) && !cfg_data[0];

  // Pixel count of a blit, registered before it is compared
  always_ff @(posedge clk) begin
    prod <= req.width * req.height;
  end

  // Slot indices
  assign hidx    = req.handle[IDX_W-1:0] - 1'b1;
  assign rd_addr = cmd.rd_walk ? walk_cnt : hidx;

  // Lowest free slot within the current group; slots past the end read as used
  always_comb begin
    used_pad = '1;
    used_pad[SLOTS-1:0] = used;
    grp_bits = used_pad[grp * GROUP_SIZE +: GROUP_SIZE];
    free_low = '0;
    for (int k = GROUP_SIZE - 1; k >= 0; k--) begin
      if (!grp_bits[k]) begin
        free_low = GROUP_BITS'(k);
      end
    end
  end

  assign free_full  = {grp, free_low};
  assign free_idx   = free_full[IDX_W-1:0];
  assign new_handle = {1'b0, free_full} + 1'b1;

  // Search and walk counters
  always_ff @(posedge clk) begin
    if (rst) begin
      grp      <= '0;
      walk_cnt <= '0;
    end else begin
      if (cmd.search_clr) begin
        grp <= '0;
      end else if (cmd.search_inc) begin
        grp <= grp + 1'b1;
      end
      if (cmd.walk_clr) begin
        walk_cnt <= '0;
      end else if (cmd.walk_inc) begin
        walk_cnt <= walk_cnt + 1'b1;
      end
    end
  end

  // Slot table memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.emit && (cmd.kind == RK_CREATED)) begin
      owner_mem[free_idx]   <= req.caller_id;
      backend_mem[free_idx] <= req.backend_answer;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_handle || cmd.rd_walk) begin
      rd_owner   <= owner_mem[rd_addr];
      rd_backend <= backend_mem[rd_addr];
    end
  end

  // Used marks; an unused slot's memory contents are never looked at
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      used <= '0;
    end else if (cmd.emit) begin
      if (cmd.kind == RK_CREATED) begin
        used[free_idx] <= 1'b1;
      end else if (cmd.kind == RK_DESTROY) begin
        used[hidx] <= 1'b0;
      end else if (cmd.kind == RK_FREED) begin
        used[walk_cnt] <= 1'b0;
      end
    end
  end

  // Status towards the controller
  assign md32 = {16'b0, max_dim};

  always_comb begin
    stat           = '0;
    stat.mode      = req.mode;
    stat.pid_zero  = (req.caller_id == 32'd0);
    stat.bp        = backend_present;
    stat.create_ok = !stat.pid_zero && (req.width != 32'd0) && (req.height != 32'd0) &&
                     (req.width <= md32) && (req.height <= md32) && backend_present;
    stat.handle_ok = !stat.pid_zero && (req.handle != 64'd0) &&
                     (req.handle <= 64'(SLOTS));
    stat.owned     = used[hidx] && (rd_owner == req.caller_id);
    stat.dims_ok   = (req.width <= md32) && (req.height <= md32) &&
                     (req.pos_x <= md32) && (req.pos_y <= md32);
    stat.prod_ok   = (prod <= {32'b0, blit_max_pixels});
    stat.buf_ok    = req.buffer_given;
    stat.blit_zero = (req.width == 32'd0) || (req.height == 32'd0);
    stat.ans_ok    = (req.backend_answer > 0);
    stat.grp_free  = !(&grp_bits);
    stat.grp_last  = (grp == GRP_W'(NGRP - 1));
    stat.walk_hit  = used[walk_cnt] && (rd_owner == req.caller_id);
    stat.walk_last = (walk_cnt == IDX_W'(SLOTS - 1));
  end

  // Result fields for each kind of result
  always_comb begin
    res_next = '0;
    res_next.last = 1'b1;
    unique case (cmd.kind)
      RK_REFUSE: begin
        res_next.status = 1'b1;
      end
      RK_REFUSE_CALL: begin
        res_next.status       = 1'b1;
        res_next.call_backend = 1'b1;
      end
      RK_CREATED: begin
        res_next.handle_out   = HANDLE_OUT_W'(new_handle);
        res_next.backend_ref  = req.backend_answer;
        res_next.call_backend = 1'b1;
      end
      RK_ACCESS: begin
        res_next.backend_ref  = rd_backend;
        res_next.call_backend = 1'b1;
      end
      RK_DONE: ;
      RK_DESTROY: begin
        res_next.backend_ref  = backend_present ? rd_backend : 32'sd0;
        res_next.call_backend = backend_present;
      end
      RK_FREED: begin
        res_next.backend_ref  = rd_backend;
        res_next.call_backend = backend_present;
        res_next.last         = 1'b0;
      end
      default: begin
        res_next.status = 1'b1;
      end
    endcase
  end

  // Output register: result_valid is high for a single cycle per result
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= res_next;
    end
  end

endmodule

FILE: hw/rtl/oht_ctrl.sv
module oht_ctrl import oht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  oht_stat_t stat,
  output logic      busy,
  output oht_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_LOOKUP   = 3'd2;
  localparam logic [2:0] S_SEARCH   = 3'd3;
  localparam logic [2:0] S_WALK_RD  = 3'd4;
  localparam logic [2:0] S_WALK_CHK = 3'd5;
  localparam logic [2:0] S_FINAL    = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Sequencing of one request
  always_comb begin
    cmd        = '0;
    cmd.kind   = RK_REFUSE;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end

      // Checks that need no table contents
      S_DECODE: begin
        unique case (stat.mode)
          MODE_CREATE: begin
            if (stat.create_ok) begin
              cmd.search_clr = 1'b1;
              state_next     = S_SEARCH;
            end else begin
              cmd.emit   = 1'b1;
              cmd.kind   = RK_REFUSE;
              state_next = S_IDLE;
            end
          end
          MODE_FILL, MODE_BLIT, MODE_POLL, MODE_DESTROY: begin
            if (stat.handle_ok) begin
              cmd.rd_handle = 1'b1;
              state_next    = S_LOOKUP;
            end else begin
              cmd.emit   = 1'b1;
              cmd.kind   = RK_REFUSE;
              state_next = S_IDLE;
            end
          end
          MODE_RELEASE: begin
            if (stat.pid_zero) begin
              cmd.emit   = 1'b1;
              cmd.kind   = RK_DONE;
              state_next = S_IDLE;
            end else begin
              cmd.walk_clr = 1'b1;
              state_next   = S_WALK_RD;
            end
          end
          default: begin
            cmd.emit   = 1'b1;
            cmd.kind   = RK_REFUSE;
            state_next = S_IDLE;
          end
        endcase
      end

      // The addressed slot has been read: ownership and argument checks
      S_LOOKUP: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
        priority if (!stat.owned) begin
          cmd.kind = RK_REFUSE;
        end else if (stat.mode == MODE_FILL) begin
          cmd.kind = (stat.dims_ok && stat.bp) ? RK_ACCESS : RK_REFUSE;
        end else if (stat.mode == MODE_BLIT) begin
          priority if (!stat.buf_ok) begin
            cmd.kind = RK_REFUSE;
          end else if (stat.blit_zero) begin
            cmd.kind = RK_DONE;
          end else if (stat.dims_ok && stat.prod_ok && stat.bp) begin
            cmd.kind = RK_ACCESS;
          end else begin
            cmd.kind = RK_REFUSE;
          end
        end else if (stat.mode == MODE_POLL) begin
          cmd.kind = (stat.buf_ok && stat.bp) ? RK_ACCESS : RK_REFUSE;
        end else if (stat.mode == MODE_DESTROY) begin
          cmd.kind = RK_DESTROY;
        end else begin
          cmd.kind = RK_REFUSE;
        end
      end

      // One group of used marks per cycle until a free slot turns up or the last group is searched
      S_SEARCH: begin
        if (stat.grp_free) begin
          cmd.emit   = 1'b1;
          cmd.kind   = stat.ans_ok ? RK_CREATED : RK_REFUSE_CALL;
          state_next = S_IDLE;
        end else if (stat.grp_last) begin
          cmd.emit   = 1'b1;
          cmd.kind   = RK_REFUSE;
          state_next = S_IDLE;
        end else begin
          cmd.search_inc = 1'b1;
        end
      end

      // Release walk: read a slot, then free it if the caller owns it
      S_WALK_RD: begin
        cmd.rd_walk = 1'b1;
        state_next  = S_WALK_CHK;
      end

      S_WALK_CHK: begin
        if (stat.walk_hit) begin
          cmd.emit = 1'b1;
          cmd.kind = RK_FREED;
        end
        if (stat.walk_last) begin
          state_next = S_FINAL;
        end else begin
          cmd.walk_inc = 1'b1;
          state_next   = S_WALK_RD;
        end
      end

      S_FINAL: begin
        cmd.emit   = 1'b1;
        cmd.kind   = RK_DONE;
        state_next = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/owned_handle_table.sv
// Channel   Ports                         Direction  Handshake
// request   start, request                in         taken when start high, busy low
// result    result_valid, result          out        high for a single cycle per result, no stall
// config    cfg_we, cfg_index, cfg_data   in         written when cfg_we high
//
// Create searches one group of eight used marks per cycle until it finds a free
// slot or has searched the last group. Fill, blit, poll and destroy wait for the
// registered read of the slot memory, unless the handle is out of range.
// Release owner does one memory read and one check per slot, unless the caller
// is zero. A new request is taken once busy falls.
// Reset and a write of zero to backend_present clear every used mark at once.
module owned_handle_table import oht_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  req_t                  request,
  output logic                  busy,
  output res_t                  result,
  output logic                  result_valid,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  oht_cmd_t  cmd;
  oht_stat_t stat;

  // Sequencer
  oht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Slot table, checks and result register
  oht_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

`ifndef NO_ASSERTIONS
  // A result only follows a cycle in which a request was being worked on.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result issued without a request in progress");

  // An accepted request keeps the block busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The final result of a request leaves the block idle.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> !busy)
    else $error("block still busy after the final result");

  // A freed-slot result of a release is always followed by more work.
  a_busy_before_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.last) |-> busy)
    else $error("release walk ended without its final result");
`endif

endmodule
